>>> src/acpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and constants of the 8-bit accumulator computer
// Transaction payloads, host operation and stop codes, the opcode map and
// the instruction decoder used by the controller and the datapath.
// ----------------------------------------------------------------------------
package acpu_pkg;

   localparam int MEM_DEPTH = 256;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int PC_W      = ADDR_W + 1;

   // Program counter value that marks a machine which has run off the end.
   localparam logic [PC_W-1:0] PC_END = PC_W'(MEM_DEPTH);

   // Highest protected address.
   localparam logic [7:0] PROT_TOP = 8'h1F;

   // Opcode map: branch opcodes are whole bytes, the rest is mode and kind.
   localparam logic [7:0] OPC_JUMP = 8'h10;
   localparam logic [7:0] OPC_BRN  = 8'h11;
   localparam logic [7:0] OPC_BRZ  = 8'h12;

   localparam logic [1:0] MODE_IMM = 2'b00;
   localparam logic [1:0] MODE_ABS = 2'b01;
   localparam logic [1:0] MODE_IND = 2'b11;

   localparam logic [5:0] KIND_LOAD  = 6'h00;
   localparam logic [5:0] KIND_ADD   = 6'h20;
   localparam logic [5:0] KIND_SUB   = 6'h21;
   localparam logic [5:0] KIND_NAND  = 6'h22;
   localparam logic [5:0] KIND_STORE = 6'h08;
   localparam logic [5:0] KIND_IN    = 6'h09;
   localparam logic [5:0] KIND_OUT   = 6'h01;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_EXEC  = 2'd2,
      OP_READ  = 2'd3
   } hostop_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_END  = 2'd1,
      ST_PROT = 2'd2,
      ST_JIP  = 2'd3
   } stop_type;

   typedef enum logic [3:0] {
      K_LOAD, K_ADD, K_SUB, K_NAND, K_STORE, K_IN, K_OUT,
      K_JUMP, K_BRN, K_BRZ, K_UNKNOWN
   } kind_type;

   typedef enum logic [1:0] {
      AM_NONE, AM_IMM, AM_ABS, AM_IND
   } amode_type;

   typedef struct packed {
      kind_type  kind;
      amode_type amode;
   } dec_type;

   typedef struct packed {
      hostop_type       op;
      logic [7:0]       address;
      logic [7:0]       value;
   } req_type;

   typedef struct packed {
      stop_type         status;
      logic             out_valid;
      logic [7:0]       out_value;
      logic [7:0]       read_value;
      logic [7:0]       accumulator_now;
      logic [PC_W-1:0]  next_pc;
      logic             took_input;
   } rsp_type;

   // Memory address sources of the single memory port.
   typedef enum logic [2:0] {
      ASEL_REQ, ASEL_PC, ASEL_PC_NEXT, ASEL_RDATA, ASEL_EA
   } asel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      accept;
      asel_type  addr_sel;
      logic      mem_we;
      logic      set_pc;
      logic      set_end;
      logic      latch_opc;
      logic      latch_opnd;
      logic      latch_ind;
      logic      exec;
      logic      respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      hostop_type op;
      logic       stopped;
      logic       pc_end;
      amode_type  amode;
   } stat_type;

   function automatic dec_type decode(input logic [7:0] opc);
      dec_type    d;
      logic [1:0] mode;
      logic [5:0] kind;
      mode    = opc[7:6];
      kind    = opc[5:0];
      d.kind  = K_UNKNOWN;
      d.amode = AM_NONE;
      if (opc == OPC_JUMP) begin
         d.kind = K_JUMP;
      end else if (opc == OPC_BRN) begin
         d.kind = K_BRN;
      end else if (opc == OPC_BRZ) begin
         d.kind = K_BRZ;
      end else if (mode == MODE_IMM) begin
         d.amode = AM_IMM;
         case (kind)
            KIND_LOAD: d.kind = K_LOAD;
            KIND_ADD:  d.kind = K_ADD;
            KIND_SUB:  d.kind = K_SUB;
            KIND_NAND: d.kind = K_NAND;
            default:   d.amode = AM_NONE;
         endcase
      end else if (mode == MODE_ABS || mode == MODE_IND) begin
         d.amode = (mode == MODE_IND) ? AM_IND : AM_ABS;
         case (kind)
            KIND_LOAD:  d.kind = K_LOAD;
            KIND_ADD:   d.kind = K_ADD;
            KIND_SUB:   d.kind = K_SUB;
            KIND_NAND:  d.kind = K_NAND;
            KIND_STORE: d.kind = K_STORE;
            KIND_IN:    d.kind = K_IN;
            KIND_OUT:   d.kind = K_OUT;
            default:    d.amode = AM_NONE;
         endcase
      end
      return d;
   endfunction

endpackage

>>> src/acpu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_datapath: registers, memory and execution logic
// Holds the 256-byte memory, accumulator, program counter and stop code,
// and carries out the commands issued by the controller.
// ----------------------------------------------------------------------------
module acpu_datapath (
   input  logic                clock,
   input  logic                reset,
   input  acpu_pkg::req_type   req_data,
   input  acpu_pkg::cmd_type   cmd,
   output acpu_pkg::stat_type  stat,
   output logic                rsp_strobe,
   output acpu_pkg::rsp_type   rsp_data
);

   logic [7:0] mem [acpu_pkg::MEM_DEPTH];

   acpu_pkg::req_type               req_ff, req_in;
   logic [7:0]                      acc_ff, acc_in;
   logic [acpu_pkg::PC_W-1:0]       pc_ff, pc_in;
   acpu_pkg::stop_type              stop_ff, stop_in;
   logic [7:0]                      opc_ff, opc_in;
   logic [7:0]                      opnd_ff, opnd_in;
   logic [7:0]                      addr_ff, addr_in;
   logic [7:0]                      rdata_ff;
   logic                            outv_ff, outv_in;
   logic [7:0]                      outval_ff, outval_in;
   logic                            took_ff, took_in;
   logic                            strobe_ff;
   acpu_pkg::rsp_type               rsp_ff, rsp_in;

   acpu_pkg::dec_type               dec;
   logic [acpu_pkg::ADDR_W-1:0]     mem_addr;
   logic                            mem_we;
   logic [7:0]                      mem_wdata;
   logic                            exec_we;
   logic [7:0]                      here;
   logic [acpu_pkg::PC_W-1:0]       pc_two;
   logic                            prot_pc;
   logic                            taken;
   logic [7:0]                      mval;

   assign dec     = acpu_pkg::decode(opc_ff);
   assign here    = pc_ff[7:0];
   assign pc_two  = {1'b0, here} + acpu_pkg::PC_W'(2);
   assign prot_pc = (here >= acpu_pkg::PROT_TOP);
   assign mval    = (dec.amode == acpu_pkg::AM_IMM) ? opnd_ff : rdata_ff;
   assign taken   = (dec.kind == acpu_pkg::K_JUMP) ||
                    (dec.kind == acpu_pkg::K_BRN && acc_ff[7]) ||
                    (dec.kind == acpu_pkg::K_BRZ && acc_ff == 8'd0);

   assign stat.op      = req_ff.op;
   assign stat.stopped = (stop_ff != acpu_pkg::ST_OK);
   assign stat.pc_end  = pc_ff[acpu_pkg::PC_W-1];
   assign stat.amode   = dec.amode;

   always_comb begin
      case (cmd.addr_sel)
         acpu_pkg::ASEL_REQ:     mem_addr = req_ff.address;
         acpu_pkg::ASEL_PC:      mem_addr = here;
         acpu_pkg::ASEL_PC_NEXT: mem_addr = here + 8'd1;
         acpu_pkg::ASEL_RDATA:   mem_addr = rdata_ff;
         acpu_pkg::ASEL_EA:      mem_addr = addr_ff;
         default:                mem_addr = here;
      endcase
   end

   always_comb begin
      req_in    = req_ff;
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      stop_in   = stop_ff;
      opc_in    = opc_ff;
      opnd_in   = opnd_ff;
      addr_in   = addr_ff;
      outv_in   = outv_ff;
      outval_in = outval_ff;
      took_in   = took_ff;
      exec_we   = 1'b0;

      if (cmd.accept) begin
         req_in    = req_data;
         outv_in   = 1'b0;
         outval_in = 8'd0;
         took_in   = 1'b0;
      end
      if (cmd.set_pc) begin
         pc_in   = {1'b0, req_ff.address};
         stop_in = acpu_pkg::ST_OK;
      end
      if (cmd.set_end) begin
         pc_in   = acpu_pkg::PC_END;
         stop_in = acpu_pkg::ST_END;
      end
      if (cmd.latch_opc) begin
         opc_in = rdata_ff;
      end
      if (cmd.latch_opnd) begin
         opnd_in = rdata_ff;
         addr_in = rdata_ff;
      end
      if (cmd.latch_ind) begin
         addr_in = rdata_ff;
      end

      if (cmd.exec) begin
         case (dec.kind)
            acpu_pkg::K_JUMP, acpu_pkg::K_BRN, acpu_pkg::K_BRZ: begin
               if (taken) begin
                  if (opnd_ff == here) begin
                     stop_in = acpu_pkg::ST_JIP;
                  end else if (opnd_ff <= acpu_pkg::PROT_TOP && prot_pc) begin
                     stop_in = acpu_pkg::ST_PROT;
                  end else begin
                     pc_in = {1'b0, opnd_ff};
                  end
               end else if (pc_two[acpu_pkg::PC_W-1]) begin
                  pc_in   = acpu_pkg::PC_END;
                  stop_in = acpu_pkg::ST_END;
               end else begin
                  pc_in = pc_two;
               end
            end
            acpu_pkg::K_UNKNOWN: begin
               if (pc_two[acpu_pkg::PC_W-1]) begin
                  pc_in   = acpu_pkg::PC_END;
                  stop_in = acpu_pkg::ST_END;
               end else begin
                  pc_in = pc_two;
               end
            end
            default: begin
               if (dec.amode != acpu_pkg::AM_IMM && addr_ff <= acpu_pkg::PROT_TOP
                   && prot_pc) begin
                  stop_in = acpu_pkg::ST_PROT;
               end else begin
                  case (dec.kind)
                     acpu_pkg::K_LOAD:  acc_in = mval;
                     acpu_pkg::K_ADD:   acc_in = acc_ff + mval;
                     acpu_pkg::K_SUB:   acc_in = acc_ff - mval;
                     acpu_pkg::K_NAND:  acc_in = ~(acc_ff & mval);
                     acpu_pkg::K_STORE: exec_we = 1'b1;
                     acpu_pkg::K_IN: begin
                        exec_we = 1'b1;
                        took_in = 1'b1;
                     end
                     acpu_pkg::K_OUT: begin
                        outv_in   = 1'b1;
                        outval_in = mval;
                     end
                     default: ;
                  endcase
                  if (pc_two[acpu_pkg::PC_W-1]) begin
                     pc_in   = acpu_pkg::PC_END;
                     stop_in = acpu_pkg::ST_END;
                  end else begin
                     pc_in = pc_two;
                  end
               end
            end
         endcase
      end
   end

   assign mem_we    = cmd.mem_we | exec_we;
   assign mem_wdata = (cmd.exec && dec.kind == acpu_pkg::K_STORE) ? acc_ff : req_ff.value;

   always_comb begin
      rsp_in.status          = stop_ff;
      rsp_in.out_valid       = outv_ff;
      rsp_in.out_value       = outval_ff;
      rsp_in.read_value      = (req_ff.op == acpu_pkg::OP_READ) ? rdata_ff : 8'd0;
      rsp_in.accumulator_now = acc_ff;
      rsp_in.next_pc         = pc_ff;
      rsp_in.took_input      = took_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 8'd0;
         pc_ff     <= '0;
         stop_ff   <= acpu_pkg::ST_OK;
         outv_ff   <= 1'b0;
         outval_ff <= 8'd0;
         took_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         pc_ff     <= pc_in;
         stop_ff   <= stop_in;
         outv_ff   <= outv_in;
         outval_ff <= outval_in;
         took_ff   <= took_in;
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      opc_ff  <= opc_in;
      opnd_ff <= opnd_in;
      addr_ff <= addr_in;
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> src/acpu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_ctrl: transaction sequencer
// State machine that walks each transaction through dispatch and response;
// an instruction adds opcode and operand fetch, optional indirection, execute.
// ----------------------------------------------------------------------------
module acpu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  acpu_pkg::stat_type  stat,
   output logic                busy,
   output acpu_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_OPC, S_OPND, S_IND, S_EXEC, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = acpu_pkg::ASEL_PC;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            case (stat.op)
               acpu_pkg::OP_WRITE: begin
                  cmd.addr_sel = acpu_pkg::ASEL_REQ;
                  cmd.mem_we   = 1'b1;
               end
               acpu_pkg::OP_START: cmd.set_pc = 1'b1;
               acpu_pkg::OP_READ:  cmd.addr_sel = acpu_pkg::ASEL_REQ;
               acpu_pkg::OP_EXEC: begin
                  if (stat.stopped) begin
                     state_in = S_RESP;
                  end else if (stat.pc_end) begin
                     cmd.set_end = 1'b1;
                  end else begin
                     state_in = S_OPC;
                  end
               end
               default: ;
            endcase
         end
         S_OPC: begin
            cmd.latch_opc = 1'b1;
            cmd.addr_sel  = acpu_pkg::ASEL_PC_NEXT;
            state_in      = S_OPND;
         end
         S_OPND: begin
            cmd.latch_opnd = 1'b1;
            cmd.addr_sel   = acpu_pkg::ASEL_RDATA;
            state_in       = (stat.amode == acpu_pkg::AM_IND) ? S_IND : S_EXEC;
         end
         S_IND: begin
            cmd.latch_ind = 1'b1;
            cmd.addr_sel  = acpu_pkg::ASEL_RDATA;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec     = 1'b1;
            cmd.addr_sel = acpu_pkg::ASEL_EA;
            state_in     = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

>>> src/accumulator_cpu_8bit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit: 8-bit accumulator computer with a 256-byte memory
// Writes, reads, start and an execute while stopped or at the end of memory
// go from dispatch straight to the result; other executes fetch opcode and
// operand, for indirect mode also the pointed-to address, then execute.
// The block takes no new transaction until the last result is shown. The
// single memory port is read once per fetch, operand and indirection step.
// The next transaction may be taken in the cycle its predecessor's result
// is shown. Synchronous reset clears accumulator, program counter and stop
// code; memory contents are undefined until written. The receiver cannot
// stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module accumulator_cpu_8bit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  acpu_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output acpu_pkg::rsp_type  rsp_data
);

   // Commands flow from the sequencer to the datapath, status flows back.
   // The datapath registers the request on acceptance, so the sequencer
   // only ever looks at the latched copy of the host operation.
   acpu_pkg::cmd_type  cmd;
   acpu_pkg::stat_type stat;

   // The sequencer owns busy: it is low only while waiting for a new
   // transaction, and a transaction is accepted when start meets busy low.
   acpu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds the memory and all architectural registers, and
   // presents each result from an output register for a single cycle.
   acpu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 8-bit accumulator computer
// Loads the whole memory, runs a directed program through every addressing
// mode, branch and stop condition, then drives random host transactions
// while a behavioural mirror of the machine predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
   import acpu_pkg::*;

   // Random host transactions after the memory load and the directed part.
   localparam int RANDOM_ITEMS = 1020;
   // Generous watchdog limit, far above what the slowest legal run needs.
   localparam int CYCLE_LIMIT  = 400000;
   // Margin above the longest latency of the block.
   localparam int SETTLE       = 16;

   // -------------------------------------------------------------------------
   // Mirror of the machine: holds its own memory, accumulator, program counter
   // and stop code, and queues the result each accepted transaction must give.
   // -------------------------------------------------------------------------
   class cpu_mirror;
      logic [7:0]      mem [MEM_DEPTH];
      logic [7:0]      acc  = '0;
      logic [PC_W-1:0] pc   = '0;
      stop_type        stop = ST_OK;
      rsp_type         expected_rsp [$];
      int              mismatches = 0;

      // One instruction at the current program counter.
      function void run_instruction(input logic [7:0] in_byte, inout rsp_type e);
         logic [PC_W-1:0] here;
         logic [PC_W-1:0] nxt;
         logic [7:0]      opc;
         logic [7:0]      opnd;
         logic [7:0]      ea;
         logic [7:0]      m;
         logic [1:0]      mode;
         logic [5:0]      kind;
         logic            taken;
         logic            alu_kind;
         logic            port_kind;
         logic            known;
         here = pc;
         nxt  = pc + 1'b1;
         opc  = mem[here[7:0]];
         // The operand fetch wraps to address 0 when the opcode sits at 255.
         opnd = mem[nxt[7:0]];
         mode = opc[7:6];
         kind = opc[5:0];
         ea   = '0;
         if (opc == OPC_JUMP || opc == OPC_BRN || opc == OPC_BRZ) begin
            taken = (opc == OPC_JUMP) || (opc == OPC_BRN && acc[7]) ||
                    (opc == OPC_BRZ && acc == 8'h00);
            if (taken) begin
               // Jumping onto itself is caught before the protection check.
               if ({1'b0, opnd} == here) begin
                  stop = ST_JIP;
               end else if (opnd <= PROT_TOP && nxt > PROT_TOP) begin
                  stop = ST_PROT;
               end else begin
                  pc = {1'b0, opnd};
               end
               return;
            end
            nxt = nxt + 1'b1;
         end else begin
            alu_kind  = (kind == KIND_LOAD) || (kind == KIND_ADD) ||
                        (kind == KIND_SUB) || (kind == KIND_NAND);
            port_kind = (kind == KIND_STORE) || (kind == KIND_IN) || (kind == KIND_OUT);
            known     = (mode == MODE_IMM && alu_kind) ||
                        ((mode == MODE_ABS || mode == MODE_IND) && (alu_kind || port_kind));
            if (known) begin
               if (mode == MODE_IMM) begin
                  m = opnd;
               end else begin
                  ea = (mode == MODE_IND) ? mem[opnd] : opnd;
                  if (ea <= PROT_TOP && nxt > PROT_TOP) begin
                     stop = ST_PROT;
                     return;
                  end
                  m = mem[ea];
               end
               case (kind)
                  KIND_LOAD:  acc = m;
                  KIND_ADD:   acc = acc + m;
                  KIND_SUB:   acc = acc - m;
                  KIND_NAND:  acc = ~(acc & m);
                  KIND_STORE: mem[ea] = acc;
                  KIND_IN: begin
                     mem[ea]      = in_byte;
                     e.took_input = 1'b1;
                  end
                  default: begin
                     e.out_valid = 1'b1;
                     e.out_value = m;
                  end
               endcase
            end
            nxt = nxt + 1'b1;
         end
         if (nxt > 9'd255) begin
            pc   = PC_END;
            stop = ST_END;
         end else begin
            pc = nxt;
         end
      endfunction

      function void accept_request(input req_type q);
         rsp_type e;
         e = '0;
         case (q.op)
            OP_WRITE: mem[q.address] = q.value;
            OP_START: begin
               pc   = {1'b0, q.address};
               stop = ST_OK;
            end
            OP_EXEC: begin
               if (stop == ST_OK) begin
                  if (pc > 9'd255) begin
                     pc   = PC_END;
                     stop = ST_END;
                  end else begin
                     run_instruction(q.value, e);
                  end
               end
            end
            OP_READ: e.read_value = mem[q.address];
         endcase
         e.status          = stop;
         e.accumulator_now = acc;
         e.next_pc         = pc;
         expected_rsp.push_back(e);
      endfunction

      function void compare_field(input string name, input logic [8:0] want,
                                  input logic [8:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("result strobe with no transaction outstanding");
            mismatches++;
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("status", 9'(want.status), 9'(got.status));
         compare_field("out_valid", 9'(want.out_valid), 9'(got.out_valid));
         compare_field("out_value", 9'(want.out_value), 9'(got.out_value));
         compare_field("read_value", 9'(want.read_value), 9'(got.read_value));
         compare_field("accumulator_now", 9'(want.accumulator_now),
                       9'(got.accumulator_now));
         compare_field("next_pc", want.next_pc, got.next_pc);
         compare_field("took_input", 9'(want.took_input), 9'(got.took_input));
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;

   cpu_mirror  mirror;
   logic [7:0] boot_image [MEM_DEPTH];
   int         cycle_count;
   // Chance in a hundred that the sender holds start low in a given cycle.
   int         idle_pct;

   accumulator_cpu_8bit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results cannot be held off, so every strobe is checked at the edge that
   // ends its cycle. Values read here are those from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         mirror.check_response(rsp_data);
      end
   end

   // Watchdog: a run that has not finished by now has lost a transaction.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   // Presents one transaction and returns at the edge that accepts it. In
   // each cycle the sender holds start low with a chance of idle_pct in a
   // hundred. The mirror is updated at the accepting edge, so stimulus chosen
   // afterwards sees the new state. Start is left as it was; the caller
   // either presents the next transaction or lowers it, so start receives
   // only one assignment per edge.
   task automatic drive(input hostop_type op, input logic [7:0] addr,
                        input logic [7:0] val);
      req_type q;
      logic    offered;
      q.op      = op;
      q.address = addr;
      q.value   = val;
      req_data <= q;
      do begin
         offered = ($urandom_range(0, 99) >= idle_pct);
         start  <= offered;
         @(posedge clock);
      end while (!offered || busy);
      mirror.accept_request(q);
   endtask

   // Holds the sender back until every outstanding result has arrived.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.outstanding() != 0) @(posedge clock);
   endtask

   // Mostly legal opcodes across every mode, with some arbitrary bytes so
   // that unknown opcodes turn up as well.
   function automatic logic [7:0] pick_opcode();
      logic [1:0] mode;
      logic [5:0] kind;
      if ($urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       return OPC_JUMP;
         1:       return OPC_BRN;
         2:       return OPC_BRZ;
         3, 4:    mode = MODE_IMM;
         5, 6:    mode = MODE_ABS;
         default: mode = MODE_IND;
      endcase
      case ($urandom_range(0, (mode == MODE_IMM) ? 3 : 6))
         0:       kind = KIND_LOAD;
         1:       kind = KIND_ADD;
         2:       kind = KIND_SUB;
         3:       kind = KIND_NAND;
         4:       kind = KIND_STORE;
         5:       kind = KIND_IN;
         default: kind = KIND_OUT;
      endcase
      return {mode, kind};
   endfunction

   // Start addresses: mostly ordinary code space, with the protected area and
   // the last few bytes of memory visited now and then.
   function automatic logic [7:0] pick_start();
      case ($urandom_range(0, 9))
         0:       return 8'($urandom_range(0, 31));
         1:       return 8'($urandom_range(248, 255));
         default: return 8'($urandom_range(32, 247));
      endcase
   endfunction

   task automatic place(input logic [7:0] addr, input logic [7:0] opc,
                        input logic [7:0] opnd);
      boot_image[addr]       = opc;
      boot_image[addr + 8'd1] = opnd;
   endtask

   initial begin
      int         sent;
      int         choice;
      logic [7:0] at;
      logic [7:0] opnd;

      mirror = new();
      idle_pct = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;

      // Background image: opcodes on even bytes, arbitrary operands on odd.
      for (int a = 0; a < MEM_DEPTH; a++) begin
         boot_image[a] = (a % 2 == 0) ? pick_opcode() : 8'($urandom_range(0, 255));
      end

      // Directed program from 0x40: immediate arithmetic with wrap-around in
      // both directions, taken branches on zero and on negative, then
      // store, indirect input, indirect subtract and output, a branch not
      // taken and finally an absolute access into the protected area.
      place(8'h40, 8'h00, 8'hFF);   // LOAD #FF
      place(8'h42, 8'h20, 8'h01);   // ADD #01, wraps to zero
      place(8'h44, OPC_BRZ, 8'h48);
      place(8'h48, 8'h21, 8'h01);   // SUB #01, wraps to FF
      place(8'h4A, OPC_BRN, 8'h4E);
      place(8'h4E, 8'h22, 8'h0F);   // NAND #0F
      place(8'h50, 8'h48, 8'hA0);   // STORE A0
      place(8'h52, 8'hC9, 8'hA1);   // IN [A1]
      place(8'h54, 8'hE1, 8'hA1);   // SUB [A1]
      place(8'h56, 8'hC1, 8'hA1);   // OUT [A1]
      place(8'h58, OPC_BRZ, 8'h40); // not taken, accumulator is non-zero
      place(8'h5A, 8'h61, 8'h05);   // SUB 05 from code space: protection fault
      place(8'hA0, 8'h00, 8'hA2);   // pointer at A1 leads to A2
      place(8'h60, OPC_JUMP, 8'h60); // jump onto itself
      place(8'h62, 8'h3F, 8'h00);   // unknown opcode, skips two bytes
      place(8'h64, OPC_JUMP, 8'h02); // branch target inside the protected area
      place(8'hFE, 8'h00, 8'h00);   // LOAD # at the end runs off memory
      place(8'h00, 8'h7E, 8'h00);   // unknown opcode, also the wrapped operand
      place(8'h02, 8'h60, 8'h05);   // protected read is allowed from below 0x20

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Every byte is written before any of them can be read or executed.
      for (int a = 0; a < MEM_DEPTH; a++) begin
         drive(OP_WRITE, 8'(a), boot_image[a]);
      end

      drive(OP_START, 8'h40, 8'($urandom_range(0, 255)));
      repeat (7) drive(OP_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      drive(OP_EXEC, 8'h00, 8'h5A);
      // The last two executes hit the protection fault and then repeat it.
      repeat (5) drive(OP_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      drive(OP_START, 8'h60, 8'h00);
      drive(OP_EXEC, 8'h00, 8'h00);
      drive(OP_START, 8'hFE, 8'h00);
      drive(OP_EXEC, 8'h00, 8'h00);
      drive(OP_START, 8'hFF, 8'hFF);
      drive(OP_EXEC, 8'hFF, 8'hFF);
      drive(OP_START, 8'h62, 8'h00);
      drive(OP_EXEC, 8'h00, 8'h00);
      drive(OP_EXEC, 8'h00, 8'h00);
      drive(OP_START, 8'h00, 8'h00);
      drive(OP_EXEC, 8'h00, 8'h00);
      drive(OP_EXEC, 8'h00, 8'h00);
      drive(OP_READ, 8'hA2, 8'h00);
      drive(OP_READ, 8'hA0, 8'h00);

      // Random part in three stretches: light sender gaps, heavy sender gaps
      // and back to back. Between stretches the sender waits for the block
      // to drain completely.
      sent     = 0;
      idle_pct = 11;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS / 3 && idle_pct == 11) begin
            wait_drained();
            idle_pct = 56;
         end else if (sent >= 2 * RANDOM_ITEMS / 3 && idle_pct == 56) begin
            wait_drained();
            idle_pct = 0;
         end

         choice = $urandom_range(0, 99);
         if (mirror.stop != ST_OK && choice < 70) begin
            // A stopped machine is usually restarted so that execution
            // carries on; otherwise the sticky stop is exercised.
            drive(OP_START, pick_start(), 8'($urandom_range(0, 255)));
            sent++;
         end else if (choice < 8) begin
            if (mirror.pc < 9'd255 && choice < 5) begin
               // Patch a fresh instruction in at the program counter.
               at   = mirror.pc[7:0];
               opnd = ($urandom_range(0, 19) == 0) ? at : 8'($urandom_range(0, 255));
               drive(OP_WRITE, at, pick_opcode());
               drive(OP_WRITE, at + 8'd1, opnd);
               sent += 2;
            end else begin
               drive(OP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               sent++;
            end
         end else if (choice < 13) begin
            drive(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            sent++;
         end else if (choice < 17) begin
            drive(OP_START, pick_start(), 8'($urandom_range(0, 255)));
            sent++;
         end else begin
            drive(OP_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            sent++;
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);

      if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
